>>> src/dda_pkg.sv
// -----------------------------------------------------------------------------
// dda_pkg
// shared constants for the dust density averager: widths, register indexes,
// reset values and the density conversion limits
// -----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

   // ring store
   localparam int DEPTH   = 64;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int DENS_W   = 18;
   localparam int SUM_W    = 24;
   localparam int BITS_W   = 5;
   localparam int SUPPLY_W = 13;
   localparam int WINDOW_W = 7;
   localparam int PROD_W   = SAMPLE_W + SUPPLY_W;
   localparam int SCALED_W = PROD_W + 5;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SUPPLY_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ADC_BITS  = 2'd0,
      REG_SUPPLY_MV = 2'd1,
      REG_WINDOW    = 2'd2
   } csr_index_type;

   localparam logic [BITS_W-1:0]   ADC_BITS_RST  = 5'd10;
   localparam logic [SUPPLY_W-1:0] SUPPLY_MV_RST = 13'd5000;
   localparam logic [WINDOW_W-1:0] WINDOW_RST    = 7'd10;

   // conversion limits
   localparam int DENS_MAX     = 92000;
   localparam int DENS_OFFSET  = 10000;
   localparam int SCALED_LIMIT = DENS_MAX + DENS_OFFSET;

   // stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

endpackage : dda_pkg

`default_nettype wire

>>> src/dda_div.sv
// -----------------------------------------------------------------------------
// dda_div
// serial signed divider for the running mean, one quotient bit per cycle,
// truncating toward zero
// -----------------------------------------------------------------------------
`default_nettype none

module dda_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [dda_pkg::SUM_W-1:0]    dividend,
   input  wire logic        [dda_pkg::COUNT_W-1:0]  divisor,
   output logic                                     done,
   output logic signed      [dda_pkg::DENS_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(dda_pkg::SUM_W);
   localparam int REM_W = dda_pkg::COUNT_W + 1;

   logic                             busy_ff,  busy_in;
   logic                             done_ff,  done_in;
   logic                             neg_ff,   neg_in;
   logic [CNT_W-1:0]                 cnt_ff,   cnt_in;
   logic [dda_pkg::SUM_W-1:0]        mag_ff,   mag_in;
   logic [REM_W-1:0]                 rem_ff,   rem_in;
   logic [dda_pkg::COUNT_W-1:0]      div_ff,   div_in;
   logic signed [dda_pkg::DENS_W-1:0] quo_ff,  quo_in;

   logic [REM_W-1:0]                 shift_rem;
   logic                             fits;
   logic [dda_pkg::SUM_W-1:0]        mag_next;

   always_comb begin
      shift_rem = {rem_ff[REM_W-2:0], mag_ff[dda_pkg::SUM_W-1]};
      fits      = shift_rem >= {1'b0, div_ff};
      mag_next  = {mag_ff[dda_pkg::SUM_W-2:0], fits};

      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[dda_pkg::SUM_W-1];
         mag_in  = dividend[dda_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         cnt_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? (shift_rem - {1'b0, div_ff}) : shift_rem;
         mag_in = mag_next;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(dda_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? (dda_pkg::DENS_W'(~mag_next) + 1'b1)
                             : dda_pkg::DENS_W'(mag_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : dda_div

`default_nettype wire

>>> src/dust_density_averager.sv
// -----------------------------------------------------------------------------
// dust_density_averager
// converts a raw dust sensor sample to density and averages the newest
// densities held in a ring store with a running sum
// -----------------------------------------------------------------------------
//  channel  direction  beat contents (lowest bits first)
//  req_     in         tdata: adc_sample[15:0]
//  rsp_     out        tdata: dust_now[17:0], dust_mean[35:18], held_count[42:36]
//  csr_     in         index 0 adc_bits, 1 supply_mv, 2 window; wdata; idle only
//
//  a sample passes from accept to result through the multiply, scale and update
//  states, then the 24-step serial divider behind the ring store read-modify-write
//  no further sample is taken until the result is loaded into the output register
//  the output register holds while rsp_tready is low; a waiting result does not
//  stop the next sample from being accepted
//  reset is synchronous; the ring store needs no clearing pass
// -----------------------------------------------------------------------------
`default_nettype none

module dust_density_averager (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // adc_sample[15:0]
   input  wire logic [dda_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // dust_now[17:0], dust_mean[35:18], held_count[42:36], zero fill
   output logic [dda_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dda_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dda_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_SCALE = 6'b000100,
      ST_UPD   = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   localparam int AW = dda_pkg::ADDR_W;
   localparam int CW = dda_pkg::COUNT_W;
   localparam int DW = dda_pkg::DENS_W;
   localparam int SW = dda_pkg::SUM_W;

   state_type                        state_ff, state_in;
   logic [dda_pkg::BITS_W-1:0]       adc_bits_ff;
   logic [dda_pkg::SUPPLY_W-1:0]     supply_ff;
   logic [dda_pkg::WINDOW_W-1:0]     window_ff;
   logic [AW-1:0]                    slot_ff,  slot_in;
   logic [CW-1:0]                    fill_ff,  fill_in;
   logic signed [SW-1:0]             sum_ff,   sum_in;
   logic [dda_pkg::SAMPLE_W-1:0]     sample_ff;
   logic [dda_pkg::PROD_W-1:0]       prod_ff;
   logic signed [DW-1:0]             dens_ff,  dens_in;
   logic [AW-1:0]                    addr_ff,  addr_in;
   logic signed [DW-1:0]             rd_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dda_pkg::RSP_DATA_W-1:0]   rsp_data_ff,  rsp_data_in;

   logic signed [DW-1:0]             hist_mem [dda_pkg::DEPTH];

   logic [dda_pkg::SCALED_W-1:0]     scaled;
   logic [dda_pkg::SCALED_W-1:0]     shifted;
   logic [CW:0]                      slot_inc;
   logic                             window_full;
   logic                             load_rsp;
   logic                             div_start;
   logic                             div_done;
   logic signed [DW-1:0]             div_quo;
   logic [dda_pkg::WINDOW_W-1:0]     window_wr;

   always_comb begin
      scaled  = {prod_ff, 4'b0000} + dda_pkg::SCALED_W'(prod_ff);
      shifted = scaled >> adc_bits_ff;
      if (shifted > dda_pkg::SCALED_W'(dda_pkg::SCALED_LIMIT)) begin
         dens_in = DW'(dda_pkg::DENS_MAX);
      end else begin
         dens_in = DW'(shifted) - DW'(dda_pkg::DENS_OFFSET);
      end
      if (CW'(slot_ff) >= window_ff) begin
         addr_in = '0;
      end else begin
         addr_in = slot_ff;
      end
   end

   always_comb begin
      window_full = fill_ff >= window_ff;
      slot_inc    = (CW + 1)'(addr_ff) + 1'b1;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      slot_in     = slot_ff;
      if (window_full) begin
         sum_in = sum_ff - SW'(rd_ff) + SW'(dens_ff);
      end else begin
         fill_in = fill_ff + 1'b1;
         sum_in  = sum_ff + SW'(dens_ff);
      end
      if (slot_inc >= (CW + 1)'(window_ff)) begin
         slot_in = '0;
      end else begin
         slot_in = AW'(slot_inc);
      end
   end

   always_comb begin
      if (csr_wdata[dda_pkg::WINDOW_W-1:0] == '0) begin
         window_wr = dda_pkg::WINDOW_W'(1);
      end else if (csr_wdata[dda_pkg::WINDOW_W-1:0] > dda_pkg::WINDOW_W'(dda_pkg::DEPTH)) begin
         window_wr = dda_pkg::WINDOW_W'(dda_pkg::DEPTH);
      end else begin
         window_wr = csr_wdata[dda_pkg::WINDOW_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      load_rsp     = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, fill_ff, div_quo, dens_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         adc_bits_ff  <= dda_pkg::ADC_BITS_RST;
         supply_ff    <= dda_pkg::SUPPLY_MV_RST;
         window_ff    <= dda_pkg::WINDOW_RST;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_UPD) begin
            slot_ff <= slot_in;
            fill_ff <= fill_in;
            sum_ff  <= sum_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dda_pkg::REG_ADC_BITS: begin
                  adc_bits_ff <= csr_wdata[dda_pkg::BITS_W-1:0];
               end
               dda_pkg::REG_SUPPLY_MV: begin
                  supply_ff <= csr_wdata;
               end
               dda_pkg::REG_WINDOW: begin
                  window_ff <= window_wr;
                  slot_ff   <= '0;
                  fill_ff   <= '0;
                  sum_ff    <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) sample_ff <= req_tdata[dda_pkg::SAMPLE_W-1:0];
      prod_ff     <= dda_pkg::PROD_W'(sample_ff) * dda_pkg::PROD_W'(supply_ff);
      if (state_ff == ST_SCALE) begin
         dens_ff <= dens_in;
         addr_ff <= addr_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // ring store, one read and one write port
   always_ff @(posedge clock) begin
      rd_ff <= hist_mem[addr_in];
      if (state_ff == ST_UPD) hist_mem[addr_ff] <= dens_ff;
   end

   dda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = (state_ff == ST_IDLE) && !req_tvalid;

endmodule : dust_density_averager

`default_nettype wire

>>> src/dda_checker.sv
// -----------------------------------------------------------------------------
// dda_checker
// port level checks for the dust density averager, bound to the top level
// -----------------------------------------------------------------------------
`default_nettype none

module dda_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic [dda_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic                               csr_valid,
   input wire logic                               csr_ready
);

   logic signed [dda_pkg::DENS_W-1:0]  now_val;
   logic signed [dda_pkg::DENS_W-1:0]  mean_val;
   logic [dda_pkg::COUNT_W-1:0]        count_val;
   logic                               csr_beat;

   assign now_val   = rsp_tdata[17:0];
   assign mean_val  = rsp_tdata[35:18];
   assign count_val = rsp_tdata[42:36];
   assign csr_beat  = csr_valid & csr_ready;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one sample in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample accepted while another is in flight");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count_val != '0 && count_val <= dda_pkg::COUNT_W'(dda_pkg::DEPTH))
      else $error("held count out of range");

   a_dens_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> now_val >= -18'sd10000 && now_val <= 18'sd92000
                  && mean_val >= -18'sd10000 && mean_val <= 18'sd92000)
      else $error("density out of range");

   // csr beat only while no sample is in flight or offered
   a_idle_csr: assert property (@(posedge clock) disable iff (reset)
      csr_beat |-> req_tready && !req_tvalid)
      else $error("csr beat while busy");

endmodule : dda_checker

bind dust_density_averager dda_checker u_dda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// self-checking bench for dust_density_averager: samples are streamed in, mostly
// under random back-pressure; the now, mean and count fields of each response beat
// are compared with an in-bench model of the density conversion, ring store and
// truncating mean, over a series of register settings from the extremes to random ones
// -----------------------------------------------------------------------------

module tb;

   localparam logic [dda_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [4:0]         zero_fill;
      logic [6:0]         held_count;
      logic signed [17:0] dust_mean;
      logic signed [17:0] dust_now;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [dda_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [dda_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [dda_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dda_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   dust_density_averager u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // model state
   logic [dda_pkg::BITS_W-1:0]   model_bits;
   logic [dda_pkg::SUPPLY_W-1:0] model_supply;
   int                           model_window;
   longint                       density_ring [dda_pkg::DEPTH];
   int                           ring_slot;
   int                           ring_fill;
   longint                       ring_total;

   reading_type                    expected_readings [$];
   logic [dda_pkg::REQ_DATA_W-1:0] sample_queue [$];
   int                  sent_count = 0;
   int                  accepted_count = 0;
   int                  error_count = 0;
   int                  send_idle_pct = 0;
   int                  take_idle_pct = 0;
   int                  stall_cycles = 0;

   // settings seen by the stimulus side
   logic [dda_pkg::BITS_W-1:0]   stim_bits = dda_pkg::ADC_BITS_RST;
   logic [dda_pkg::SUPPLY_W-1:0] stim_supply = dda_pkg::SUPPLY_MV_RST;

   task automatic flag(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   function automatic void clear_ring();
      ring_slot = 0;
      ring_fill = 0;
      ring_total = 0;
   endfunction

   function automatic int clamp_window(input logic [dda_pkg::WINDOW_W-1:0] value);
      if (value < 1) return 1;
      if (value > dda_pkg::DEPTH) return dda_pkg::DEPTH;
      return int'(value);
   endfunction

   function automatic void apply_register(input logic [dda_pkg::CSR_IDX_W-1:0] idx,
                                          input logic [dda_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         dda_pkg::REG_ADC_BITS: begin
            model_bits = value[dda_pkg::BITS_W-1:0];
         end
         dda_pkg::REG_SUPPLY_MV: begin
            model_supply = value;
         end
         dda_pkg::REG_WINDOW: begin
            model_window = clamp_window(value[dda_pkg::WINDOW_W-1:0]);
            clear_ring();
         end
         default: begin
         end
      endcase
   endfunction

   function automatic reading_type average_density(
         input logic [dda_pkg::REQ_DATA_W-1:0] sample);
      logic [63:0] scaled;
      longint      density;
      longint      mean;
      int          slot;
      reading_type r;
      scaled = (64'd17 * 64'(sample) * 64'(model_supply)) >> model_bits;
      if (scaled > 64'(dda_pkg::SCALED_LIMIT)) density = dda_pkg::DENS_MAX;
      else density = longint'(scaled) - dda_pkg::DENS_OFFSET;
      slot = ring_slot;
      if (slot >= model_window) slot = 0;
      if (ring_fill >= model_window) ring_total -= density_ring[slot];
      else ring_fill++;
      density_ring[slot] = density;
      ring_total += density;
      slot++;
      if (slot >= model_window) slot = 0;
      ring_slot = slot;
      mean = ring_total / longint'(ring_fill);
      r.zero_fill = '0;
      r.held_count = ring_fill[6:0];
      r.dust_mean = mean[17:0];
      r.dust_now = density[17:0];
      return r;
   endfunction

   // mostly samples below saturation for the current setting
   function automatic logic [dda_pkg::REQ_DATA_W-1:0] pick_sample();
      longint lim;
      if ($urandom_range(99) < 35 || stim_supply == 0)
         return dda_pkg::REQ_DATA_W'($urandom);
      lim = ((longint'(dda_pkg::SCALED_LIMIT) + 1) << stim_bits)
            / (17 * longint'(stim_supply));
      if (lim > 65535) lim = 65535;
      return dda_pkg::REQ_DATA_W'($urandom_range(int'(lim), 0));
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata <= sample_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      reading_type got;
      reading_type want;
      if (reset) begin
         model_bits = dda_pkg::ADC_BITS_RST;
         model_supply = dda_pkg::SUPPLY_MV_RST;
         model_window = clamp_window(dda_pkg::WINDOW_RST);
         clear_ring();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = reading_type'(rsp_tdata);
            if (expected_readings.size() == 0) begin
               flag($sformatf("result beat with nothing pending: %h", rsp_tdata));
            end else begin
               want = expected_readings.pop_front();
               if (got.dust_now !== want.dust_now)
                  flag($sformatf("dust_now got %0d, expected %0d",
                                 got.dust_now, want.dust_now));
               if (got.dust_mean !== want.dust_mean)
                  flag($sformatf("dust_mean got %0d, expected %0d",
                                 got.dust_mean, want.dust_mean));
               if (got.held_count !== want.held_count)
                  flag($sformatf("held_count got %0d, expected %0d",
                                 got.held_count, want.held_count));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(average_density(req_tdata));
            accepted_count++;
         end
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_wdata);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic wait_idle();
      while (accepted_count != sent_count || expected_readings.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [dda_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [dda_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == dda_pkg::REG_ADC_BITS) stim_bits = value[dda_pkg::BITS_W-1:0];
      if (idx == dda_pkg::REG_SUPPLY_MV) stim_supply = value;
   endtask

   // random upper bits ride along with the narrow registers
   task automatic set_levels(input int bits, input int supply, input int win);
      write_register(dda_pkg::REG_ADC_BITS,
                     (dda_pkg::CSR_DATA_W'($urandom) & ~13'h1F)
                     | dda_pkg::CSR_DATA_W'(bits));
      write_register(dda_pkg::REG_SUPPLY_MV, dda_pkg::CSR_DATA_W'(supply));
      write_register(dda_pkg::REG_WINDOW,
                     (dda_pkg::CSR_DATA_W'($urandom) & ~13'h7F)
                     | dda_pkg::CSR_DATA_W'(win));
   endtask

   task automatic send_random(input int count);
      repeat (count) begin
         sample_queue.push_back(pick_sample());
         sent_count++;
      end
      wait_idle();
   endtask

   initial begin : stimulus
      logic [dda_pkg::REQ_DATA_W-1:0] corner_samples [22];
      corner_samples = '{
         16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
         16'd1228, 16'd1229, 16'd1230, 16'd118, 16'd120, 16'd121, 16'd0, 16'd7,
         16'd500, 16'd1000, 16'd1100, 16'hFFFF, 16'd300, 16'd0};
      send_idle_pct = 27;
      take_idle_pct = 51;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, window wraps after ten beats
      foreach (corner_samples[i]) begin
         sample_queue.push_back(corner_samples[i]);
         sent_count++;
      end
      wait_idle();

      set_levels(8, 1000, 1);
      send_random(120);
      set_levels(16, 6000, 64);
      send_random(300);
      // supply change keeps the history
      write_register(dda_pkg::REG_SUPPLY_MV, 13'd3300);
      send_random(100);

      send_idle_pct = 51;
      take_idle_pct = 27;
      set_levels(0, 8191, 0);
      send_random(60);
      set_levels(31, 0, 127);
      send_random(80);
      set_levels(12, 5000, 65);
      send_random(200);
      write_register(REG_UNUSED, dda_pkg::CSR_DATA_W'($urandom));
      write_register(dda_pkg::REG_ADC_BITS, 13'd10);
      send_random(100);

      send_idle_pct = 0;
      take_idle_pct = 0;
      repeat (8) begin
         set_levels(($urandom_range(99) < 80) ? $urandom_range(16, 8) : $urandom_range(31),
                    ($urandom_range(99) < 80) ? $urandom_range(6000, 1000)
                                              : $urandom_range(8191),
                    ($urandom_range(99) < 80) ? $urandom_range(64, 1)
                                              : $urandom_range(127));
         send_random(100);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0)
         flag($sformatf("%0d results never arrived", expected_readings.size()));
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
